### src/pjq_pkg.sv
// Shared constants, codes, job entry type and clamp helpers for the priority job queue.
package pjq_pkg;

  // Queue sizing
  localparam int CLASS_DEPTH = 16;
  localparam int PTR_W       = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int FILL_W      = $clog2(CLASS_DEPTH + 1);
  localparam int SUM_W       = FILL_W + 1;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int PAGES_W  = 14;
  localparam int COPIES_W = 7;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int JOBS_W   = 6;

  // Job limits
  localparam int MAX_PAGES  = 10000;
  localparam int MAX_COPIES = 100;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One stored job
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PAGES_W-1:0]  pages;
    logic [COPIES_W-1:0] copies;
  } job_entry_t;

  // Clamp a page count into 1..MAX_PAGES
  function automatic logic [PAGES_W-1:0] clamp_pages(input logic [PAGES_W-1:0] v);
    logic [PAGES_W-1:0] r;
    if (v == '0) begin
      r = PAGES_W'(1);
    end else if (v > PAGES_W'(MAX_PAGES)) begin
      r = PAGES_W'(MAX_PAGES);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Clamp a copy count into 1..MAX_COPIES
  function automatic logic [COPIES_W-1:0] clamp_copies(input logic [COPIES_W-1:0] v);
    logic [COPIES_W-1:0] r;
    if (v == '0) begin
      r = COPIES_W'(1);
    end else if (v > COPIES_W'(MAX_COPIES)) begin
      r = COPIES_W'(MAX_COPIES);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### src/pjq_class_fifo.sv
// Circular FIFO for one priority class: flop storage, head/tail pointers and fill count.
module pjq_class_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      pop,
  input  pjq_pkg::job_entry_t       push_entry,
  output pjq_pkg::job_entry_t       head_entry,
  output logic [pjq_pkg::FILL_W-1:0] fill,
  output logic                      full
);

  localparam logic [pjq_pkg::PTR_W-1:0] LAST_PTR = pjq_pkg::PTR_W'(pjq_pkg::CLASS_DEPTH - 1);

  pjq_pkg::job_entry_t            slots [pjq_pkg::CLASS_DEPTH];
  logic [pjq_pkg::PTR_W-1:0]      head;
  logic [pjq_pkg::PTR_W-1:0]      tail;
  logic [pjq_pkg::PTR_W-1:0]      head_next;
  logic [pjq_pkg::PTR_W-1:0]      tail_next;
  logic [pjq_pkg::FILL_W-1:0]     fill_next;

  assign full       = (fill == pjq_pkg::FILL_W'(pjq_pkg::CLASS_DEPTH));
  assign head_entry = slots[head];

  // Pointer and count updates; the caller never pushes when full or pops when empty
  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (push) begin
      tail_next = (tail == LAST_PTR) ? '0 : tail + 1'b1;
      fill_next = fill + 1'b1;
    end else if (pop) begin
      head_next = (head == LAST_PTR) ? '0 : head + 1'b1;
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  // Storage write at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_entry;
    end
  end

  // One action per cycle: never push and pop together
  a_no_push_pop: assert property (@(posedge clk) disable iff (rst) !(push && pop))
    else $error("class fifo pushed and popped in one cycle");

  // Pop only with something stored
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> (fill != '0))
    else $error("class fifo popped while empty");

  // Push only with room left
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("class fifo pushed while full");

  // Count follows the transaction
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |=> (fill == $past(fill) + 1'b1))
    else $error("class fifo count did not rise on push");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop |=> (fill == $past(fill) - 1'b1))
    else $error("class fifo count did not fall on pop");

endmodule

### src/two_class_priority_job_queue_top.sv
// Two-class strict-priority job queue: input register, queue update logic, result register.
//
// Takes one transaction (enqueue, dequeue or peek) in every clock cycle; busy is high
// only during reset. A transaction accepted at one rising edge is captured in the input
// register; at the next edge it is applied to the two class FIFOs and its result is loaded
// into the result register, with done high for one cycle: one result per cycle sustained.
// The queue pointers and fill counts update in the same edge that loads the result
// register, so back-to-back transactions see each other.
// Urgent jobs always leave before normal jobs; each class holds CLASS_DEPTH jobs.
module two_class_priority_job_queue_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pjq_pkg::ACTION_W-1:0]  action,
  input  logic [pjq_pkg::PAGES_W-1:0]   page_count,
  input  logic [pjq_pkg::COPIES_W-1:0]  copy_count,
  input  logic                          is_urgent,
  output logic                          done,
  output logic [pjq_pkg::STATUS_W-1:0]  status,
  output logic [pjq_pkg::ID_W-1:0]      job_id,
  output logic [pjq_pkg::PAGES_W-1:0]   job_pages,
  output logic [pjq_pkg::COPIES_W-1:0]  job_copies,
  output logic                          job_urgent,
  output logic [pjq_pkg::JOBS_W-1:0]    queued_jobs
);

  // Input register
  logic                          start_q;
  logic [pjq_pkg::ACTION_W-1:0]  action_q;
  logic [pjq_pkg::PAGES_W-1:0]   page_q;
  logic [pjq_pkg::COPIES_W-1:0]  copy_q;
  logic                          urgent_q;

  // Id counter
  logic [pjq_pkg::ID_W-1:0]      next_job_id;

  // FIFO hookup
  pjq_pkg::job_entry_t           new_entry;
  pjq_pkg::job_entry_t           u_head;
  pjq_pkg::job_entry_t           n_head;
  logic [pjq_pkg::FILL_W-1:0]    u_fill;
  logic [pjq_pkg::FILL_W-1:0]    n_fill;
  logic                          u_full;
  logic                          n_full;
  logic                          push_u;
  logic                          push_n;
  logic                          pop_u;
  logic                          pop_n;

  // Decode
  logic                          is_enq;
  logic                          is_deq;
  logic                          is_peek;
  logic                          u_avail;
  logic                          n_avail;
  logic [pjq_pkg::SUM_W-1:0]     total_next;

  // Result next values
  logic [pjq_pkg::STATUS_W-1:0]  status_next;
  logic [pjq_pkg::ID_W-1:0]      job_id_next;
  logic [pjq_pkg::PAGES_W-1:0]   job_pages_next;
  logic [pjq_pkg::COPIES_W-1:0]  job_copies_next;
  logic                          job_urgent_next;

  assign busy = rst;

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      start_q <= 1'b0;
    end else begin
      start_q <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      action_q <= action;
      page_q   <= page_count;
      copy_q   <= copy_count;
      urgent_q <= is_urgent;
    end
  end

  // Action decode and class selection
  assign is_enq  = start_q && (action_q == pjq_pkg::ACT_ENQ);
  assign is_deq  = start_q && (action_q == pjq_pkg::ACT_DEQ);
  assign is_peek = start_q && (action_q == pjq_pkg::ACT_PEEK);
  assign u_avail = (u_fill != '0);
  assign n_avail = (n_fill != '0);

  assign push_u = is_enq && urgent_q && !u_full;
  assign push_n = is_enq && !urgent_q && !n_full;
  assign pop_u  = is_deq && u_avail;
  assign pop_n  = is_deq && !u_avail && n_avail;

  assign new_entry.id     = next_job_id;
  assign new_entry.pages  = pjq_pkg::clamp_pages(page_q);
  assign new_entry.copies = pjq_pkg::clamp_copies(copy_q);

  pjq_class_fifo u_urgent_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push_u),
    .pop        (pop_u),
    .push_entry (new_entry),
    .head_entry (u_head),
    .fill       (u_fill),
    .full       (u_full)
  );

  pjq_class_fifo u_normal_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push_n),
    .pop        (pop_n),
    .push_entry (new_entry),
    .head_entry (n_head),
    .fill       (n_fill),
    .full       (n_full)
  );

  // Id counter: every enqueue uses up an id, full or not
  always_ff @(posedge clk) begin
    if (rst) begin
      next_job_id <= pjq_pkg::ID_W'(1);
    end else if (is_enq) begin
      next_job_id <= next_job_id + 1'b1;
    end
  end

  // Jobs waiting after this transaction
  assign total_next = pjq_pkg::SUM_W'(u_fill) + pjq_pkg::SUM_W'(n_fill)
                    + pjq_pkg::SUM_W'(push_u || push_n)
                    - pjq_pkg::SUM_W'(pop_u || pop_n);

  // Result selection
  always_comb begin
    status_next     = pjq_pkg::ST_OK;
    job_id_next     = '0;
    job_pages_next  = '0;
    job_copies_next = '0;
    job_urgent_next = 1'b0;
    case (action_q)
      pjq_pkg::ACT_ENQ: begin
        job_id_next = next_job_id;
        if (urgent_q ? u_full : n_full) begin
          status_next = pjq_pkg::ST_FULL;
        end
      end
      pjq_pkg::ACT_DEQ, pjq_pkg::ACT_PEEK: begin
        if (u_avail) begin
          job_id_next     = u_head.id;
          job_pages_next  = u_head.pages;
          job_copies_next = u_head.copies;
          job_urgent_next = 1'b1;
        end else if (n_avail) begin
          job_id_next     = n_head.id;
          job_pages_next  = n_head.pages;
          job_copies_next = n_head.copies;
        end else begin
          status_next = pjq_pkg::ST_EMPTY;
        end
      end
      default: begin
        // unused action: report the count only
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start_q;
    end
  end

  always_ff @(posedge clk) begin
    if (start_q) begin
      status      <= status_next;
      job_id      <= job_id_next;
      job_pages   <= job_pages_next;
      job_copies  <= job_copies_next;
      job_urgent  <= job_urgent_next;
      queued_jobs <= pjq_pkg::JOBS_W'(total_next);
    end
  end

  // Peek leaves both queues untouched
  a_peek_no_pop: assert property (@(posedge clk) disable iff (rst)
    is_peek |-> !(pop_u || pop_n))
    else $error("peek removed a job");

  // Urgent class drains first
  a_urgent_first: assert property (@(posedge clk) disable iff (rst)
    pop_n |-> (u_fill == '0))
    else $error("normal job left ahead of an urgent job");

  // Every captured transaction gives one result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    start_q |=> done)
    else $error("transaction produced no result");

  // Id counter steps exactly on enqueue
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    is_enq |=> (next_job_id == $past(next_job_id) + 1'b1))
    else $error("job id counter did not advance on enqueue");

endmodule

### bench/two_class_priority_job_queue_top_test.sv
// Self-checking testbench for the two-class strict-priority job queue.
`timescale 1ns / 100ps

module two_class_priority_job_queue_top_test;

  // Action code the block leaves unused: state holds, result carries the count only
  localparam logic [pjq_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int URGENT = 1;
  localparam int NORMAL = 0;

  typedef struct {
    logic [pjq_pkg::ACTION_W-1:0] action;
    logic [pjq_pkg::PAGES_W-1:0]  pages;
    logic [pjq_pkg::COPIES_W-1:0] copies;
    logic                         urgent;
  } job_request_t;

  typedef struct {
    logic [pjq_pkg::STATUS_W-1:0] status;
    logic [pjq_pkg::ID_W-1:0]     id;
    logic [pjq_pkg::PAGES_W-1:0]  pages;
    logic [pjq_pkg::COPIES_W-1:0] copies;
    logic                         urgent;
    logic [pjq_pkg::JOBS_W-1:0]   queued;
  } job_report_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [pjq_pkg::ACTION_W-1:0] action = pjq_pkg::ACT_DEQ;
  logic [pjq_pkg::PAGES_W-1:0]  page_count = '0;
  logic [pjq_pkg::COPIES_W-1:0] copy_count = '0;
  logic                         is_urgent = 1'b0;
  logic                         done;
  logic [pjq_pkg::STATUS_W-1:0] status;
  logic [pjq_pkg::ID_W-1:0]     job_id;
  logic [pjq_pkg::PAGES_W-1:0]  job_pages;
  logic [pjq_pkg::COPIES_W-1:0] job_copies;
  logic                         job_urgent;
  logic [pjq_pkg::JOBS_W-1:0]   queued_jobs;

  two_class_priority_job_queue_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .page_count  (page_count),
    .copy_count  (copy_count),
    .is_urgent   (is_urgent),
    .done        (done),
    .status      (status),
    .job_id      (job_id),
    .job_pages   (job_pages),
    .job_copies  (job_copies),
    .job_urgent  (job_urgent),
    .queued_jobs (queued_jobs)
  );

  // Stimulus, expected reports and bookkeeping
  job_request_t job_requests[$];
  job_report_t  expected_reports[$];
  int           requests_queued = 0;
  int           requests_taken = 0;
  int           send_idle_pct = 12;
  int           mismatch_count = 0;
  logic         request_taken = 1'b0;

  // Shadow copy of both class FIFOs, index 1 urgent, 0 normal
  pjq_pkg::job_entry_t           shadow_store[2][pjq_pkg::CLASS_DEPTH];
  logic [pjq_pkg::PTR_W-1:0]     shadow_head[2];
  logic [pjq_pkg::PTR_W-1:0]     shadow_tail[2];
  int                            shadow_fill[2];
  logic [pjq_pkg::ID_W-1:0]      shadow_next_id;

  initial begin
    shadow_head = '{'0, '0};
    shadow_tail = '{'0, '0};
    shadow_fill = '{0, 0};
    shadow_next_id = pjq_pkg::ID_W'(1);
  end

  // Clock: 4 ns period
  initial begin
    forever #2 clk = ~clk;
  end

  // Pin a count into 1..hi
  function automatic int unsigned bound_count(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [pjq_pkg::PTR_W-1:0] next_slot(logic [pjq_pkg::PTR_W-1:0] p);
    return (int'(p) >= pjq_pkg::CLASS_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // Apply one transaction to the shadow queues and return the report it yields
  function automatic job_report_t apply_queue_action(job_request_t req);
    job_report_t         rep;
    int                  cls;
    pjq_pkg::job_entry_t ent;
    rep = '{status: pjq_pkg::ST_OK, id: '0, pages: '0, copies: '0, urgent: 1'b0,
            queued: '0};
    cls = -1;
    case (req.action)
      pjq_pkg::ACT_ENQ: begin
        cls = req.urgent ? URGENT : NORMAL;
        rep.id = shadow_next_id;
        shadow_next_id = shadow_next_id + 1'b1;
        if (shadow_fill[cls] >= pjq_pkg::CLASS_DEPTH) begin
          rep.status = pjq_pkg::ST_FULL;
        end else begin
          ent.id = rep.id;
          ent.pages = pjq_pkg::PAGES_W'(bound_count(32'(req.pages), pjq_pkg::MAX_PAGES));
          ent.copies = pjq_pkg::COPIES_W'(bound_count(32'(req.copies),
                                                      pjq_pkg::MAX_COPIES));
          shadow_store[cls][shadow_tail[cls]] = ent;
          shadow_tail[cls] = next_slot(shadow_tail[cls]);
          shadow_fill[cls]++;
        end
      end
      pjq_pkg::ACT_DEQ, pjq_pkg::ACT_PEEK: begin
        if (shadow_fill[URGENT] > 0) cls = URGENT;
        else if (shadow_fill[NORMAL] > 0) cls = NORMAL;
        if (cls < 0) begin
          rep.status = pjq_pkg::ST_EMPTY;
        end else begin
          ent = shadow_store[cls][shadow_head[cls]];
          rep.id = ent.id;
          rep.pages = ent.pages;
          rep.copies = ent.copies;
          rep.urgent = (cls == URGENT);
          if (req.action == pjq_pkg::ACT_DEQ) begin
            shadow_head[cls] = next_slot(shadow_head[cls]);
            shadow_fill[cls]--;
          end
        end
      end
      default: ;
    endcase
    rep.queued = pjq_pkg::JOBS_W'(shadow_fill[URGENT] + shadow_fill[NORMAL]);
    return rep;
  endfunction

  function automatic void check_field(string name, logic [pjq_pkg::ID_W-1:0] exp_v,
                                      logic [pjq_pkg::ID_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Monitor: check reports against the shadow, then log any accepted transaction
  always @(posedge clk) begin
    job_report_t  exp_rep;
    job_request_t req;
    if (!rst && done) begin
      if (expected_reports.size() == 0) begin
        $error("report with no transaction outstanding: status %0d id %0d", status, job_id);
        mismatch_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        check_field("status", pjq_pkg::ID_W'(exp_rep.status), pjq_pkg::ID_W'(status));
        check_field("job_id", exp_rep.id, job_id);
        check_field("job_pages", pjq_pkg::ID_W'(exp_rep.pages), pjq_pkg::ID_W'(job_pages));
        check_field("job_copies", pjq_pkg::ID_W'(exp_rep.copies),
                    pjq_pkg::ID_W'(job_copies));
        check_field("job_urgent", pjq_pkg::ID_W'(exp_rep.urgent),
                    pjq_pkg::ID_W'(job_urgent));
        check_field("queued_jobs", pjq_pkg::ID_W'(exp_rep.queued),
                    pjq_pkg::ID_W'(queued_jobs));
      end
    end
    request_taken = 1'b0;
    if (!rst && start && !busy) begin
      req = '{action: action, pages: page_count, copies: copy_count, urgent: is_urgent};
      expected_reports.push_back(apply_queue_action(req));
      requests_taken++;
      request_taken = 1'b1;
    end
  end

  // Driver: present the next request at the falling edge, with random gaps
  always @(negedge clk) begin
    job_request_t req;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || request_taken) begin
      if (job_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = job_requests.pop_front();
        action <= req.action;
        page_count <= req.pages;
        copy_count <= req.copies;
        is_urgent <= req.urgent;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_job(logic [pjq_pkg::ACTION_W-1:0] act, int unsigned pg,
                          int unsigned cp, logic urg);
    job_requests.push_back('{action: act, pages: pjq_pkg::PAGES_W'(pg),
                             copies: pjq_pkg::COPIES_W'(cp), urgent: urg});
    requests_queued++;
  endtask

  function automatic int unsigned random_pages();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 20) return $urandom_range(16383);
    if (r < 25) return pjq_pkg::MAX_PAGES;
    return $urandom_range(pjq_pkg::MAX_PAGES, 1);
  endfunction

  function automatic int unsigned random_copies();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 20) return $urandom_range(127);
    if (r < 25) return pjq_pkg::MAX_COPIES;
    return $urandom_range(pjq_pkg::MAX_COPIES, 1);
  endfunction

  // Bursts leaning toward filling or draining so both full and empty get hit
  task automatic add_random_bursts(int count);
    int                           added;
    int                           mode;
    int                           len;
    int                           urg_pct;
    int                           enq_pct;
    int                           deq_pct;
    int unsigned                  r;
    logic [pjq_pkg::ACTION_W-1:0] act;
    added = 0;
    while (added < count) begin
      mode = $urandom_range(2);
      len = $urandom_range(40, 8);
      urg_pct = $urandom_range(100);
      enq_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
      deq_pct = (mode == 0) ? 10 : (mode == 1) ? 55 : 35;
      repeat (len) begin
        r = $urandom_range(99);
        if (r < enq_pct) act = pjq_pkg::ACT_ENQ;
        else if (r < enq_pct + deq_pct) act = pjq_pkg::ACT_DEQ;
        else if (r < 97) act = pjq_pkg::ACT_PEEK;
        else act = ACT_NONE;
        push_job(act, random_pages(), random_copies(), $urandom_range(99) < urg_pct);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (requests_taken != requests_queued || expected_reports.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Test sequence
  initial begin
    // Empty queue cases, then clamping at both ends and the unused action
    push_job(pjq_pkg::ACT_DEQ, 5, 5, 1'b0);
    push_job(pjq_pkg::ACT_PEEK, 5, 5, 1'b1);
    push_job(ACT_NONE, 16383, 127, 1'b1);
    push_job(pjq_pkg::ACT_ENQ, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_ENQ, 16383, 127, 1'b0);
    push_job(pjq_pkg::ACT_ENQ, pjq_pkg::MAX_PAGES, pjq_pkg::MAX_COPIES, 1'b1);
    push_job(pjq_pkg::ACT_ENQ, pjq_pkg::MAX_PAGES + 1, pjq_pkg::MAX_COPIES + 1, 1'b1);
    push_job(pjq_pkg::ACT_ENQ, 1, 1, 1'b1);
    push_job(pjq_pkg::ACT_PEEK, 0, 0, 1'b0);
    push_job(ACT_NONE, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_PEEK, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_ENQ, 9999, 99, 1'b0);
    push_job(pjq_pkg::ACT_ENQ, 2, 2, 1'b1);
    push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);
    push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);

    // Fill both classes past capacity, then drain past empty
    repeat (pjq_pkg::CLASS_DEPTH + 2)
      push_job(pjq_pkg::ACT_ENQ, random_pages(), random_copies(), 1'b1);
    repeat (pjq_pkg::CLASS_DEPTH + 2)
      push_job(pjq_pkg::ACT_ENQ, random_pages(), random_copies(), 1'b0);
    push_job(pjq_pkg::ACT_PEEK, 0, 0, 1'b0);
    repeat (2 * pjq_pkg::CLASS_DEPTH + 2) push_job(pjq_pkg::ACT_DEQ, 0, 0, 1'b0);

    repeat (6) @(negedge clk);
    rst = 1'b0;

    add_random_bursts(270);
    wait_drained();

    send_idle_pct = 64;
    add_random_bursts(270);
    wait_drained();

    send_idle_pct = 0;
    add_random_bursts(270);
    wait_drained();

    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("two_class_priority_job_queue_top test passed");
    end else begin
      $display("two_class_priority_job_queue_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2800000;
    $display("two_class_priority_job_queue_top test failed");
    $finish;
  end

endmodule

### two_class_priority_job_queue_top.f
src/pjq_pkg.sv
src/pjq_class_fifo.sv
src/two_class_priority_job_queue_top.sv
bench/two_class_priority_job_queue_top_test.sv
